FILE: design/assert_macros.svh
// assertion macros used by extended_int_alu
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition that never holds outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");

`endif

FILE: design/eia_pkg.sv
// shared types and codes of the extended integer alu
// no dependencies
`timescale 1ns / 1ps

package eia_pkg;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MOD = 3'd4,
    CMD_CMP = 3'd5,
    CMD_NOP6 = 3'd6,
    CMD_NOP7 = 3'd7
  } cmd_t;

  localparam logic [1:0] ORD_LESS      = 2'd0;
  localparam logic [1:0] ORD_EQUAL     = 2'd1;
  localparam logic [1:0] ORD_GREATER   = 2'd2;
  localparam logic [1:0] ORD_UNORDERED = 2'd3;

  // control and flag bits that ride with a word down the chain
  typedef struct packed {
    logic valid;
    cmd_t cmd;
    logic a_pos;
    logic a_nan;
    logic a_inf;
    logic b_pos;
    logic b_nan;
    logic b_inf;
  } ctl_t;

endpackage

FILE: design/eia_cell.sv
// one cell of the shift-add / shift-subtract chain, one magnitude bit per cell
// depends on eia_pkg
`timescale 1ns / 1ps

module eia_cell #(
  parameter int W   = 64,
  parameter int BIT = 63
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  eia_pkg::ctl_t     ctl_in,
  input  logic [W-1:0]      a_in,
  input  logic [W-1:0]      b_in,
  input  logic [W-1:0]      rem_in,
  input  logic [W-1:0]      quo_in,
  input  logic              ovf_in,
  output eia_pkg::ctl_t     ctl_out,
  output logic [W-1:0]      a_out,
  output logic [W-1:0]      b_out,
  output logic [W-1:0]      rem_out,
  output logic [W-1:0]      quo_out,
  output logic              ovf_out
);

  logic [W+1:0] acc;
  logic [W:0]   sh;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] rem_next;
  logic [W-1:0] quo_next;
  logic         ovf_next;

  // multiply msb first: acc = 2*acc + (b bit ? a : 0), sticky overflow
  // divide msb first: restoring step on the partial remainder
  always_comb begin
    acc      = {1'b0, rem_in, 1'b0} + {2'b00, (b_in[BIT] ? a_in : '0)};
    sh       = {rem_in, a_in[BIT]};
    diff     = sh - {1'b0, b_in};
    ge       = (sh >= {1'b0, b_in});
    quo_next = {quo_in[W-2:0], ge};
    ovf_next = ovf_in;
    if (ctl_in.cmd == eia_pkg::CMD_MUL) begin
      rem_next = acc[W-1:0];
      ovf_next = ovf_in | (|acc[W+1:W]);
    end else begin
      rem_next = ge ? diff[W-1:0] : sh[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_out   <= a_in;
      b_out   <= b_in;
      rem_out <= rem_next;
      quo_out <= quo_next;
      ovf_out <= ovf_next;
    end
  end

endmodule

FILE: design/eia_finish.sv
// last stage: special values, add, subtract, compare, mul/div/mod, result register
// depends on eia_pkg
`timescale 1ns / 1ps

module eia_finish #(
  parameter int W = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  eia_pkg::ctl_t ctl_in,
  input  logic [W-1:0]  a_in,
  input  logic [W-1:0]  b_in,
  input  logic [W-1:0]  rem_in,
  input  logic [W-1:0]  quo_in,
  input  logic          ovf_in,
  output logic          valid,
  output logic          r_positive,
  output logic [63:0]   r_magnitude,
  output logic          r_is_nan,
  output logic          r_is_inf,
  output logic [1:0]    order
);

  logic         bp;
  logic         spec;
  logic         a_zero;
  logic         b_zero;
  logic [W:0]   sum;
  logic         a_lt_b;
  logic         a_eq_b;
  logic [1:0]   ra;
  logic [1:0]   rb;
  logic         pos_next;
  logic [W-1:0] mag_next;
  logic         nan_next;
  logic         inf_next;
  logic [1:0]   ord_next;

  always_comb begin
    bp       = (ctl_in.cmd == eia_pkg::CMD_SUB) ? ~ctl_in.b_pos : ctl_in.b_pos;
    spec     = ctl_in.a_nan | ctl_in.a_inf | ctl_in.b_nan | ctl_in.b_inf;
    a_zero   = (a_in == '0);
    b_zero   = (b_in == '0);
    sum      = {1'b0, a_in} + {1'b0, b_in};
    a_lt_b   = (a_in < b_in);
    a_eq_b   = (a_in == b_in);
    // rank: negative infinity, negative finite, positive finite, positive infinity
    ra       = ctl_in.a_pos ? (ctl_in.a_inf ? 2'd3 : 2'd2) : (ctl_in.a_inf ? 2'd0 : 2'd1);
    rb       = ctl_in.b_pos ? (ctl_in.b_inf ? 2'd3 : 2'd2) : (ctl_in.b_inf ? 2'd0 : 2'd1);
    pos_next = 1'b0;
    mag_next = '0;
    nan_next = 1'b0;
    inf_next = 1'b0;
    ord_next = eia_pkg::ORD_LESS;
    unique case (ctl_in.cmd) inside
      eia_pkg::CMD_ADD, eia_pkg::CMD_SUB: begin
        pos_next = ctl_in.a_pos;
        mag_next = a_in;
        if (spec) begin
          nan_next = ctl_in.a_nan | ctl_in.b_nan
                   | (ctl_in.a_inf & ctl_in.b_inf & (ctl_in.a_pos != bp));
          inf_next = ~nan_next & (ctl_in.a_inf | ctl_in.b_inf);
          pos_next = ctl_in.b_inf ? bp : ctl_in.a_pos;
        end else if (ctl_in.a_pos == bp) begin
          if (sum[W]) begin
            inf_next = 1'b1;
          end else begin
            mag_next = sum[W-1:0];
          end
        end else if (a_lt_b) begin
          pos_next = ~ctl_in.a_pos;
          mag_next = b_in - a_in;
        end else begin
          mag_next = a_in - b_in;
        end
      end
      eia_pkg::CMD_MUL: begin
        pos_next = (ctl_in.a_pos == ctl_in.b_pos);
        mag_next = a_in;
        if (spec) begin
          nan_next = ctl_in.a_nan | ctl_in.b_nan | (ctl_in.a_inf & b_zero)
                   | (a_zero & ctl_in.b_inf);
          inf_next = ~nan_next & (ctl_in.a_inf | ctl_in.b_inf);
        end else if (b_zero) begin
          mag_next = '0;
        end else if (ovf_in) begin
          inf_next = 1'b1;
        end else begin
          mag_next = rem_in;
        end
      end
      eia_pkg::CMD_DIV: begin
        pos_next = (ctl_in.a_pos == ctl_in.b_pos);
        if (spec | b_zero) begin
          nan_next = ctl_in.a_nan | ctl_in.b_nan | (ctl_in.a_inf & ctl_in.b_inf)
                   | (a_zero & b_zero);
          inf_next = ~nan_next & (ctl_in.a_inf | (~a_zero & b_zero));
          mag_next = (~nan_next & ~inf_next & ctl_in.b_inf) ? '0 : a_in;
        end else begin
          mag_next = quo_in;
        end
      end
      eia_pkg::CMD_MOD: begin
        pos_next = ctl_in.a_pos;
        if (b_zero) begin
          nan_next = 1'b1;
          mag_next = a_in;
        end else begin
          nan_next = ctl_in.a_nan;
          inf_next = ctl_in.a_inf;
          mag_next = rem_in;
        end
      end
      eia_pkg::CMD_CMP: begin
        if (ctl_in.a_nan | ctl_in.b_nan) begin
          ord_next = eia_pkg::ORD_UNORDERED;
        end else if (ra != rb) begin
          ord_next = (ra < rb) ? eia_pkg::ORD_LESS : eia_pkg::ORD_GREATER;
        end else if (ctl_in.a_inf | a_eq_b) begin
          ord_next = eia_pkg::ORD_EQUAL;
        end else if (a_lt_b == ctl_in.a_pos) begin
          ord_next = eia_pkg::ORD_LESS;
        end else begin
          ord_next = eia_pkg::ORD_GREATER;
        end
      end
      default: begin
        ord_next = eia_pkg::ORD_LESS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_positive  <= pos_next;
      r_magnitude <= 64'(mag_next);
      r_is_nan    <= nan_next;
      r_is_inf    <= inf_next;
      order       <= ord_next;
    end
  end

endmodule

FILE: design/extended_int_alu.sv
// extended integer alu: sign-magnitude add, subtract, multiply, divide, modulo, compare
// stages from accept to result word: input register, one chain cell
// per magnitude bit, result register
// throughput one word per cycle; the whole chain holds while a result waits under out_stall
// synchronous active-high reset clears the valid bits of every stage
// depends on eia_pkg, eia_cell, eia_finish, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module extended_int_alu #(
  parameter int MAG_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic        a_positive,
  input  logic [63:0] a_magnitude,
  input  logic        a_is_nan,
  input  logic        a_is_inf,
  input  logic        b_positive,
  input  logic [63:0] b_magnitude,
  input  logic        b_is_nan,
  input  logic        b_is_inf,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        r_positive,
  output logic [63:0] r_magnitude,
  output logic        r_is_nan,
  output logic        r_is_inf,
  output logic [1:0]  order
);

  localparam int W = MAG_WIDTH;

  eia_pkg::ctl_t ctl_s [0:W];
  logic [W-1:0]  a_s   [0:W];
  logic [W-1:0]  b_s   [0:W];
  logic [W-1:0]  rem_s [0:W];
  logic [W-1:0]  quo_s [0:W];
  logic          ovf_s [0:W];
  logic          en;

  // the chain advances unless a result is held at the output
  assign en       = ~(out_valid & out_stall);
  assign in_stall = out_valid & out_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s[0].valid <= 1'b0;
    end else if (en) begin
      ctl_s[0].valid <= in_valid;
      ctl_s[0].cmd   <= eia_pkg::cmd_t'(command);
      ctl_s[0].a_pos <= a_positive;
      ctl_s[0].a_nan <= a_is_nan;
      ctl_s[0].a_inf <= a_is_inf;
      ctl_s[0].b_pos <= b_positive;
      ctl_s[0].b_nan <= b_is_nan;
      ctl_s[0].b_inf <= b_is_inf;
      a_s[0]         <= a_magnitude[W-1:0];
      b_s[0]         <= b_magnitude[W-1:0];
      rem_s[0]       <= '0;
      quo_s[0]       <= '0;
      ovf_s[0]       <= 1'b0;
    end
  end

  // chain of cells, msb first
  for (genvar i = 0; i < W; i++) begin : g_cell
    eia_cell #(.W(W), .BIT(W-1-i)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctl_in (ctl_s[i]),
      .a_in   (a_s[i]),
      .b_in   (b_s[i]),
      .rem_in (rem_s[i]),
      .quo_in (quo_s[i]),
      .ovf_in (ovf_s[i]),
      .ctl_out(ctl_s[i+1]),
      .a_out  (a_s[i+1]),
      .b_out  (b_s[i+1]),
      .rem_out(rem_s[i+1]),
      .quo_out(quo_s[i+1]),
      .ovf_out(ovf_s[i+1])
    );
  end

  // result stage
  eia_finish #(.W(W)) u_finish (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .ctl_in     (ctl_s[W]),
    .a_in       (a_s[W]),
    .b_in       (b_s[W]),
    .rem_in     (rem_s[W]),
    .quo_in     (quo_s[W]),
    .ovf_in     (ovf_s[W]),
    .valid      (out_valid),
    .r_positive (r_positive),
    .r_magnitude(r_magnitude),
    .r_is_nan   (r_is_nan),
    .r_is_inf   (r_is_inf),
    .order      (order)
  );

  // checks
  `ASSERT_NEVER(a_valid_known, clk, rst, $isunknown(out_valid))
  `ASSERT_IMPL(a_order_alone, clk, rst, out_valid && (order != eia_pkg::ORD_LESS),
               !r_is_nan && !r_is_inf && !r_positive && (r_magnitude == 64'd0))
  `ASSERT_IMPL(a_stall_needs_word, clk, rst, in_stall, out_valid)
  `ASSERT_IMPL(a_held_result, clk, rst, out_valid && out_stall,
               ##1 out_valid && $stable(r_magnitude))

endmodule

FILE: tb/sv/extended_int_alu_checker.sv
// checker for the extended integer alu: watches both channels, predicts each result word
// and compares it field by field; depends on eia_pkg
`timescale 1ns / 1ps

module extended_int_alu_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  command,
  input  logic        a_positive,
  input  logic [63:0] a_magnitude,
  input  logic        a_is_nan,
  input  logic        a_is_inf,
  input  logic        b_positive,
  input  logic [63:0] b_magnitude,
  input  logic        b_is_nan,
  input  logic        b_is_inf,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        r_positive,
  input  logic [63:0] r_magnitude,
  input  logic        r_is_nan,
  input  logic        r_is_inf,
  input  logic [1:0]  order,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic        pos;
    logic [63:0] mag;
    logic        nan;
    logic        inf;
  } xval_t;

  typedef struct packed {
    xval_t      r;
    logic [1:0] ord;
  } alu_word_t;

  alu_word_t expected_words[$];

  function automatic xval_t sum_of(xval_t a, xval_t b);
    xval_t r;
    r = a;
    if (a.nan || a.inf || b.nan || b.inf) begin
      r.nan = a.nan || b.nan || (a.inf && b.inf && a.pos != b.pos);
      r.inf = !r.nan && (a.inf || b.inf);
      r.pos = b.inf ? b.pos : a.pos;
    end else if (a.pos == b.pos) begin
      if (a.mag > ~b.mag) r.inf = 1'b1;
      else r.mag = a.mag + b.mag;
    end else if (a.mag < b.mag) begin
      r.pos = !a.pos;
      r.mag = b.mag - a.mag;
    end else begin
      r.mag = a.mag - b.mag;
    end
    return r;
  endfunction

  function automatic xval_t product_of(xval_t a, xval_t b);
    xval_t r;
    r = a;
    r.pos = (a.pos == b.pos);
    if (a.nan || a.inf || b.nan || b.inf) begin
      r.nan = a.nan || b.nan || (a.inf && b.mag == 0) || (a.mag == 0 && b.inf);
      r.inf = !r.nan && (a.inf || b.inf);
    end else if (b.mag == 0) begin
      r.mag = '0;
    end else if (a.mag > 64'hFFFF_FFFF_FFFF_FFFF / b.mag) begin
      r.inf = 1'b1;
    end else begin
      r.mag = a.mag * b.mag;
    end
    return r;
  endfunction

  function automatic xval_t quotient_of(xval_t a, xval_t b);
    xval_t r;
    r = a;
    r.pos = (a.pos == b.pos);
    if (b.mag == 0 || a.nan || a.inf || b.nan || b.inf) begin
      r.nan = a.nan || b.nan || (a.inf && b.inf) || (a.mag == 0 && b.mag == 0);
      r.inf = !r.nan && (a.inf || (a.mag != 0 && b.mag == 0));
      if (!r.nan && !r.inf && b.inf) r.mag = '0;
    end else begin
      r.mag = a.mag / b.mag;
    end
    return r;
  endfunction

  function automatic int rank_of(xval_t v);
    int k;
    k = v.inf ? 2 : 1;
    return v.pos ? k : -k;
  endfunction

  function automatic logic [1:0] ordering_of(xval_t a, xval_t b);
    int ra;
    int rb;
    logic [63:0] x;
    logic [63:0] y;
    if (a.nan || b.nan) return eia_pkg::ORD_UNORDERED;
    ra = rank_of(a);
    rb = rank_of(b);
    if (ra != rb) return (ra < rb) ? eia_pkg::ORD_LESS : eia_pkg::ORD_GREATER;
    if (ra == 2 || ra == -2) return eia_pkg::ORD_EQUAL;
    x = (ra > 0) ? a.mag : b.mag;
    y = (ra > 0) ? b.mag : a.mag;
    if (x < y) return eia_pkg::ORD_LESS;
    return (x == y) ? eia_pkg::ORD_EQUAL : eia_pkg::ORD_GREATER;
  endfunction

  function automatic alu_word_t alu_result_of(eia_pkg::cmd_t cmd, xval_t a, xval_t b);
    alu_word_t w;
    w = '0;
    case (cmd)
      eia_pkg::CMD_ADD: w.r = sum_of(a, b);
      eia_pkg::CMD_SUB: begin
        b.pos = !b.pos;
        w.r = sum_of(a, b);
      end
      eia_pkg::CMD_MUL: w.r = product_of(a, b);
      eia_pkg::CMD_DIV: w.r = quotient_of(a, b);
      eia_pkg::CMD_MOD: begin
        w.r = a;
        if (b.mag == 0) begin
          w.r.nan = 1'b1;
          w.r.inf = 1'b0;
        end else begin
          w.r.mag = a.mag % b.mag;
        end
      end
      eia_pkg::CMD_CMP: w.ord = ordering_of(a, b);
      default: w = '0;
    endcase
    return w;
  endfunction

  assign pending = expected_words.size();

  // predict on every accepted input word, compare every accepted result word
  always @(posedge clk) begin
    xval_t a;
    xval_t b;
    alu_word_t got;
    alu_word_t exp_w;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.r = '{r_positive, r_magnitude, r_is_nan, r_is_inf};
        got.ord = order;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (got !== exp_w) begin
            $display("%0t: mismatch exp pos=%b mag=%h nan=%b inf=%b ord=%0d", $time,
                     exp_w.r.pos, exp_w.r.mag, exp_w.r.nan, exp_w.r.inf, exp_w.ord);
            $display("%0t:          got pos=%b mag=%h nan=%b inf=%b ord=%0d", $time,
                     got.r.pos, got.r.mag, got.r.nan, got.r.inf, got.ord);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        a = '{a_positive, a_magnitude, a_is_nan, a_is_inf};
        b = '{b_positive, b_magnitude, b_is_nan, b_is_inf};
        expected_words = {expected_words,
                          alu_result_of(eia_pkg::cmd_t'(command), a, b)};
      end
    end
  end
endmodule

FILE: tb/sv/extended_int_alu_tb.sv
// top of the extended integer alu testbench: clock, reset, stimulus and verdict
// depends on eia_pkg, extended_int_alu and extended_int_alu_checker
`timescale 1ns / 1ps

module extended_int_alu_tb;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  command;
  logic        a_positive;
  logic [63:0] a_magnitude;
  logic        a_is_nan;
  logic        a_is_inf;
  logic        b_positive;
  logic [63:0] b_magnitude;
  logic        b_is_nan;
  logic        b_is_inf;
  logic        out_valid;
  logic        out_stall;
  logic        r_positive;
  logic [63:0] r_magnitude;
  logic        r_is_nan;
  logic        r_is_inf;
  logic [1:0]  order;
  int          fail_count;
  int          pending;
  bit          stall_enable;

  extended_int_alu u_dut (.*);
  extended_int_alu_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // random operand magnitude leaning on the interesting corners
  function automatic logic [63:0] pick_mag();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 64'd1;
      2: return '1;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'(1) << $urandom_range(0, 63);
      5: return 64'($urandom_range(0, 20));
      6: return {32'd0, 32'($urandom())};
      default: return {32'($urandom()), 32'($urandom())};
    endcase
  endfunction

  // receiver side: random stall per result word
  initial begin
    int k;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (stall_enable) begin
        k = $urandom_range(0, 6);
        out_stall <= (k != 0);
        repeat (k) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(negedge clk);
      while (!(out_valid && !out_stall) && stall_enable) @(negedge clk);
    end
  end

  task automatic send_word(eia_pkg::cmd_t c, logic ap, logic [63:0] am, logic an, logic ai,
                           logic bp, logic [63:0] bm, logic bn, logic bi, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    a_positive <= ap; a_magnitude <= am; a_is_nan <= an; a_is_inf <= ai;
    b_positive <= bp; b_magnitude <= bm; b_is_nan <= bn; b_is_inf <= bi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int gap);
    logic special;
    special = ($urandom_range(0, 3) == 0);
    send_word(eia_pkg::cmd_t'($urandom_range(0, 7)), 1'($urandom()), pick_mag(),
              special & 1'($urandom()), special & 1'($urandom()),
              1'($urandom()), pick_mag(),
              special & 1'($urandom()), special & 1'($urandom()), gap);
  endtask

  initial begin
    int n;
    stall_enable = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    command = eia_pkg::CMD_ADD;
    a_positive = 1'b0; a_magnitude = '0; a_is_nan = 1'b0; a_is_inf = 1'b0;
    b_positive = 1'b0; b_magnitude = '0; b_is_nan = 1'b0; b_is_inf = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: overflow, zero over zero, inf over inf, modulo by zero, ranks
    send_word(eia_pkg::CMD_ADD, 1'b1, '1, 1'b0, 1'b0, 1'b1, 64'd1, 1'b0, 1'b0, 0);
    send_word(eia_pkg::CMD_SUB, 1'b1, 64'd3, 1'b0, 1'b0, 1'b1, 64'd5, 1'b0, 1'b0, 0);
    send_word(eia_pkg::CMD_ADD, 1'b1, 64'd7, 1'b0, 1'b1, 1'b0, 64'd2, 1'b0, 1'b1, 0);
    send_word(eia_pkg::CMD_SUB, 1'b0, 64'd7, 1'b0, 1'b1, 1'b0, 64'd2, 1'b0, 1'b1, 0);
    send_word(eia_pkg::CMD_ADD, 1'b0, 64'd9, 1'b1, 1'b0, 1'b1, 64'd2, 1'b0, 1'b0, 0);
    send_word(eia_pkg::CMD_MUL, 1'b1, '1, 1'b0, 1'b0, 1'b0, 64'd2, 1'b0, 1'b0, 0);
    send_word(eia_pkg::CMD_MUL, 1'b1, '1, 1'b0, 1'b0, 1'b1, '0, 1'b0, 1'b0, 0);
    send_word(eia_pkg::CMD_MUL, 1'b1, '0, 1'b0, 1'b0, 1'b1, '0, 1'b0, 1'b1, 0);
    send_word(eia_pkg::CMD_MUL, 1'b0, 64'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 64'hFFFF_FFFF,
              1'b0, 1'b0, 0);
    send_word(eia_pkg::CMD_DIV, 1'b1, '0, 1'b0, 1'b0, 1'b1, '0, 1'b0, 1'b0, 0);
    send_word(eia_pkg::CMD_DIV, 1'b1, 64'd5, 1'b0, 1'b1, 1'b0, 64'd1, 1'b0, 1'b1, 0);
    send_word(eia_pkg::CMD_DIV, 1'b0, 64'd5, 1'b0, 1'b0, 1'b1, '0, 1'b0, 1'b0, 0);
    send_word(eia_pkg::CMD_DIV, 1'b1, 64'd5, 1'b0, 1'b0, 1'b1, 64'd3, 1'b0, 1'b1, 0);
    send_word(eia_pkg::CMD_DIV, 1'b1, '1, 1'b0, 1'b0, 1'b0, 64'd7, 1'b0, 1'b0, 0);
    send_word(eia_pkg::CMD_MOD, 1'b0, 64'd17, 1'b0, 1'b0, 1'b1, '0, 1'b0, 1'b0, 0);
    send_word(eia_pkg::CMD_MOD, 1'b0, '1, 1'b1, 1'b1, 1'b1, 64'd10, 1'b0, 1'b0, 0);
    send_word(eia_pkg::CMD_CMP, 1'b0, '0, 1'b0, 1'b0, 1'b1, '0, 1'b0, 1'b0, 0);
    send_word(eia_pkg::CMD_CMP, 1'b0, 64'd4, 1'b0, 1'b1, 1'b0, 64'd9, 1'b0, 1'b1, 0);
    send_word(eia_pkg::CMD_CMP, 1'b0, 64'd4, 1'b0, 1'b0, 1'b0, 64'd9, 1'b0, 1'b0, 0);
    send_word(eia_pkg::CMD_CMP, 1'b1, 64'd4, 1'b0, 1'b1, 1'b1, '1, 1'b0, 1'b0, 0);
    send_word(eia_pkg::CMD_CMP, 1'b1, 64'd4, 1'b0, 1'b0, 1'b1, 64'd4, 1'b1, 1'b0, 0);
    send_word(eia_pkg::CMD_NOP6, 1'b1, '1, 1'b1, 1'b1, 1'b1, '1, 1'b1, 1'b1, 0);
    send_word(eia_pkg::CMD_NOP7, 1'b1, '1, 1'b0, 1'b0, 1'b1, '1, 1'b0, 1'b0, 0);

    // back-to-back without idling, then random idling on both sides
    for (n = 0; n < 650; n++) begin
      if (n == 100) stall_enable = 1'b1;
      if (n == 350) begin
        // hold off until every expected word has come out
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      send_random((n < 100) ? 0 : $urandom_range(0, 6));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
